// File: hdl/mrd_pkg.sv
package mrd_pkg;

    // Width of every result field that carries a count or a position
    localparam int unsigned FIELD_W = 17;

    // Mode register codes
    typedef enum logic [1:0] {
        MODE_LENGTH = 2'd0,
        MODE_FIRST  = 2'd1,
        MODE_LAST   = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    // One result request as it travels through the output buffer
    typedef struct packed {
        logic [FIELD_W-1:0] run_value;
        logic               has_value;
        logic               end_of_sequence;
        logic [FIELD_W-1:0] runs_found;
    } result_t;

endpackage

// File: hdl/mrd_out_buffer.sv
module mrd_out_buffer
    import mrd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    // upstream side
    input  logic    push_valid,
    input  result_t push_data,
    output logic    full,
    // downstream side
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_data
);

    logic    head_valid_reg;
    logic    head_valid_next;
    result_t head_reg;
    result_t head_next;
    logic    spare_valid_reg;
    logic    spare_valid_next;
    result_t spare_reg;
    result_t spare_next;
    logic    pop;

    assign pop          = head_valid_reg && !result_stall;
    assign full         = spare_valid_reg;
    assign result_valid = head_valid_reg;
    assign result_data  = head_reg;

    // Two-entry skid: head drives the port, spare catches a request during a stall
    always_comb
    begin
        head_valid_next  = head_valid_reg;
        head_next        = head_reg;
        spare_valid_next = spare_valid_reg;
        spare_next       = spare_reg;
        if (spare_valid_reg)
        begin
            // upstream is held off while spare is occupied
            if (pop)
            begin
                head_next        = spare_reg;
                spare_valid_next = 1'b0;
            end
        end
        else if (!head_valid_reg || pop)
        begin
            head_valid_next = push_valid;
            if (push_valid)
            begin
                head_next = push_data;
            end
        end
        else if (push_valid)
        begin
            spare_valid_next = 1'b1;
            spare_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg  <= head_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

endmodule

// File: hdl/mask_run_detector_unit.sv
// Run detector over a stream of samples, nonzero counts as set.
// Throughput: one sample per cycle while the output buffer is not full; the sequence
// state and the result are both computed in the acceptance cycle, and a two-entry
// output buffer, which registers each result request, absorbs result stalls.
// Reset: asynchronous active low; mode returns to run lengths, all sequence state
// is cleared and the output buffer is emptied.
module mask_run_detector_unit
    import mrd_pkg::*;
#(
    parameter longint unsigned MAX_LENGTH = 65536
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_data,
    // sample channel
    input  logic signed [63:0]        sample,
    input  logic                      is_last,
    input  logic                      sample_valid,
    output logic                      sample_stall,
    // result channel
    output logic [FIELD_W-1:0]        run_value,
    output logic                      has_value,
    output logic                      end_of_sequence,
    output logic [FIELD_W-1:0]        runs_found,
    output logic                      result_valid,
    input  logic                      result_stall
);

    // Counters hold the saturation bound itself and are never narrower than a field
    localparam int unsigned BOUND_W = $clog2(MAX_LENGTH + 64'd1);
    localparam int unsigned CNT_W   = (BOUND_W > FIELD_W) ? BOUND_W : FIELD_W;
    localparam logic [CNT_W-1:0] BOUND = CNT_W'(MAX_LENGTH);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v >= BOUND) ? BOUND : v + CNT_W'(1);
    endfunction

    mode_t            mode_reg;
    logic             in_run_reg;
    logic             in_run_next;
    logic [CNT_W-1:0] elem_idx_reg;
    logic [CNT_W-1:0] elem_idx_next;
    logic [CNT_W-1:0] run_len_reg;
    logic [CNT_W-1:0] run_len_next;
    logic [CNT_W-1:0] end_pos_reg;
    logic [CNT_W-1:0] end_pos_next;
    logic [CNT_W-1:0] emit_cnt_reg;
    logic [CNT_W-1:0] emit_cnt_next;

    logic             accept;
    logic             is_set;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] emit_cnt_inc;
    logic             emit;
    logic [CNT_W-1:0] value;
    logic             push_valid;
    result_t          push_data;
    result_t          result_data;

    assign accept = sample_valid && !sample_stall;
    assign is_set = (sample != 64'sd0);
    assign position = sat_inc(elem_idx_reg);

    // Run tracking per mode
    always_comb
    begin
        in_run_next  = in_run_reg;
        run_len_next = run_len_reg;
        end_pos_next = end_pos_reg;
        emit         = 1'b0;
        value        = '0;
        unique case (mode_reg)
            MODE_LENGTH:
            begin
                if (is_set)
                begin
                    run_len_next = in_run_reg ? sat_inc(run_len_reg) : CNT_W'(1);
                    in_run_next  = 1'b1;
                    emit         = is_last;
                    value        = run_len_next;
                end
                else if (in_run_reg)
                begin
                    in_run_next = 1'b0;
                    emit        = 1'b1;
                    value       = run_len_reg;
                end
            end
            MODE_FIRST:
            begin
                in_run_next = is_set;
                if (is_set && !in_run_reg)
                begin
                    emit  = 1'b1;
                    value = position;
                end
            end
            MODE_LAST:
            begin
                if (is_set)
                begin
                    end_pos_next = position;
                    in_run_next  = 1'b1;
                    emit         = is_last;
                    value        = position;
                end
                else if (in_run_reg)
                begin
                    in_run_next = 1'b0;
                    emit        = 1'b1;
                    value       = end_pos_reg;
                end
            end
            default:
            begin
                // unused mode: state holds, index still advances
            end
        endcase
    end

    assign emit_cnt_inc = emit ? sat_inc(emit_cnt_reg) : emit_cnt_reg;

    // End of sequence clears everything after the result is formed
    always_comb
    begin
        if (is_last)
        begin
            elem_idx_next = '0;
            emit_cnt_next = '0;
        end
        else
        begin
            elem_idx_next = position;
            emit_cnt_next = emit_cnt_inc;
        end
    end

    // Result request
    assign push_valid                = accept && (emit || is_last);
    assign push_data.run_value       = emit ? value[FIELD_W-1:0] : '0;
    assign push_data.has_value       = emit;
    assign push_data.end_of_sequence = is_last;
    assign push_data.runs_found      = emit_cnt_inc[FIELD_W-1:0];

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LENGTH;
        end
        else if (cfg_we)
        begin
            mode_reg <= mode_t'(cfg_data);
        end
    end

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg   <= 1'b0;
            elem_idx_reg <= '0;
            run_len_reg  <= '0;
            end_pos_reg  <= '0;
            emit_cnt_reg <= '0;
        end
        else if (accept)
        begin
            in_run_reg   <= is_last ? 1'b0 : in_run_next;
            elem_idx_reg <= elem_idx_next;
            run_len_reg  <= is_last ? '0 : run_len_next;
            end_pos_reg  <= is_last ? '0 : end_pos_next;
            emit_cnt_reg <= emit_cnt_next;
        end
    end

    // Output buffer
    mrd_out_buffer u_out_buffer (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_valid   (push_valid),
        .push_data    (push_data),
        .full         (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    assign run_value       = result_data.run_value;
    assign has_value       = result_data.has_value;
    assign end_of_sequence = result_data.end_of_sequence;
    assign runs_found      = result_data.runs_found;

endmodule

// File: bench/mask_run_detector_unit_test.sv
module mask_run_detector_unit_test;
    import mrd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam logic [FIELD_W-1:0] RUN_CAP = 17'd65536;
    localparam logic signed [63:0] MOST_NEG = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] MOST_POS = 64'sh7FFF_FFFF_FFFF_FFFF;

    // one sample request as queued for the driver
    typedef struct {
        logic signed [63:0] value;
        logic               is_end;
    } sample_req_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [1:0]                cfg_data = MODE_LENGTH;
    logic signed [63:0]        sample = '0;
    logic                      is_last = 1'b0;
    logic                      sample_valid = 1'b0;
    logic                      sample_stall;
    logic [FIELD_W-1:0]        run_value;
    logic                      has_value;
    logic                      end_of_sequence;
    logic [FIELD_W-1:0]        runs_found;
    logic                      result_valid;
    logic                      result_stall = 1'b0;

    sample_req_t pending_samples[$];
    result_t     results_due[$];
    int unsigned items_queued = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    bit          idling_on = 1'b1;

    // shadow of the block's mode and sequence state
    mode_t              active_mode = MODE_LENGTH;
    logic               seq_in_run = 1'b0;
    logic [FIELD_W-1:0] seq_index = '0;
    logic [FIELD_W-1:0] seq_run_len = '0;
    logic [FIELD_W-1:0] seq_end_pos = '0;
    logic [FIELD_W-1:0] seq_emitted = '0;

    mask_run_detector_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .sample          (sample),
        .is_last         (is_last),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .run_value       (run_value),
        .has_value       (has_value),
        .end_of_sequence (end_of_sequence),
        .runs_found      (runs_found),
        .result_valid    (result_valid),
        .result_stall    (result_stall)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // counter with saturation at the run cap
    function automatic logic [FIELD_W-1:0] bump(input logic [FIELD_W-1:0] v);
        return (v >= RUN_CAP) ? RUN_CAP : v + 1'b1;
    endfunction

    // advance the shadow state by one accepted sample, queue the result it causes
    task automatic track_sample(input logic signed [63:0] s, input logic lst);
        logic               set;
        logic               emit;
        logic [FIELD_W-1:0] pos;
        logic [FIELD_W-1:0] val;
        result_t            r;
        set  = (s != 0);
        emit = 1'b0;
        val  = '0;
        pos  = bump(seq_index);
        case (active_mode)
            MODE_LENGTH:
            begin
                if (set)
                begin
                    seq_run_len = seq_in_run ? bump(seq_run_len) : 17'd1;
                    seq_in_run  = 1'b1;
                    if (lst)
                    begin
                        emit = 1'b1;
                        val  = seq_run_len;
                    end
                end
                else if (seq_in_run)
                begin
                    seq_in_run = 1'b0;
                    emit       = 1'b1;
                    val        = seq_run_len;
                end
            end
            MODE_FIRST:
            begin
                if (set)
                begin
                    if (!seq_in_run)
                    begin
                        seq_in_run = 1'b1;
                        emit       = 1'b1;
                        val        = pos;
                    end
                end
                else
                begin
                    seq_in_run = 1'b0;
                end
            end
            MODE_LAST:
            begin
                if (set)
                begin
                    seq_end_pos = pos;
                    seq_in_run  = 1'b1;
                    if (lst)
                    begin
                        emit = 1'b1;
                        val  = seq_end_pos;
                    end
                end
                else if (seq_in_run)
                begin
                    seq_in_run = 1'b0;
                    emit       = 1'b1;
                    val        = seq_end_pos;
                end
            end
            default:
            begin
            end
        endcase
        seq_index = pos;
        if (emit)
            seq_emitted = bump(seq_emitted);
        if (emit || lst)
        begin
            r.run_value       = emit ? val : '0;
            r.has_value       = emit;
            r.end_of_sequence = lst;
            r.runs_found      = seq_emitted;
            results_due.push_back(r);
        end
        // a last sample starts a fresh sequence
        if (lst)
        begin
            seq_in_run  = 1'b0;
            seq_index   = '0;
            seq_run_len = '0;
            seq_end_pos = '0;
            seq_emitted = '0;
        end
    endtask

    task automatic queue_sample(input logic signed [63:0] v, input logic lst);
        sample_req_t req;
        req.value  = v;
        req.is_end = lst;
        pending_samples.push_back(req);
        items_queued++;
    endtask

    // nonzero value: a single bit somewhere or a full random word
    function automatic logic signed [63:0] random_set_value();
        logic signed [63:0] v;
        if ($urandom_range(0, 2) == 0)
            v = 64'sd1 << $urandom_range(0, 63);
        else
            v = {$urandom, $urandom};
        if (v == 0)
            v = MOST_NEG;
        return v;
    endfunction

    // sequence built from alternating runs of set and clear samples
    task automatic queue_sequence(input bit leave_open);
        int unsigned total;
        int unsigned n;
        int unsigned k;
        bit          level;
        total = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
        level = $urandom_range(0, 1);
        n     = 0;
        while (n < total)
        begin
            k = $urandom_range(1, 6);
            for (int unsigned j = 0; j < k && n < total; j++)
            begin
                n++;
                queue_sample(level ? random_set_value() : 64'sd0,
                             (n == total) && !leave_open);
            end
            level = !level;
        end
    endtask

    // block is idle once everything sent has been answered
    task automatic settle();
        while (pending_samples.size() != 0 || sample_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_mode(input mode_t m);
        settle();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we      <= 1'b0;
        active_mode = m;
    endtask

    // driver: presents queued sample requests, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        sample_req_t req;
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            send_gap = 0;
        end
        else if (!sample_valid || !sample_stall)
        begin
            if (sample_valid)
                track_sample(sample, is_last);
            if (send_gap > 0)
            begin
                send_gap--;
                sample_valid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                req = pending_samples.pop_front();
                sample       <= req.value;
                is_last      <= req.is_end;
                sample_valid <= 1'b1;
                if (idling_on && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 19);
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each accepted result, stalls in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                got = '{run_value, has_value, end_of_sequence, runs_found};
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: value=%0d has=%0b eos=%0b runs=%0d",
                                 got.run_value, got.has_value, got.end_of_sequence,
                                 got.runs_found);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: want value=%0d has=%0b eos=%0b runs=%0d,",
                                      " got value=%0d has=%0b eos=%0b runs=%0d"},
                                     want.run_value, want.has_value, want.end_of_sequence,
                                     want.runs_found, got.run_value, got.has_value,
                                     got.end_of_sequence, got.runs_found);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned start;
        mode_t       m;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // run lengths from the reset mode: single samples, wide values, high bits only
        queue_sample(64'sd0, 1'b1);
        queue_sample(64'sd1, 1'b1);
        queue_sample(64'sh100, 1'b0);
        queue_sample(MOST_NEG, 1'b0);
        queue_sample(64'sd0, 1'b0);
        queue_sample(MOST_POS, 1'b0);
        queue_sample(64'sd1, 1'b1);

        // start positions, run broken by the last sample
        write_mode(MODE_FIRST);
        queue_sample(-64'sd1, 1'b0);
        queue_sample(64'sh1_0000_0000, 1'b0);
        queue_sample(64'sd0, 1'b0);
        queue_sample(64'sh80, 1'b0);
        queue_sample(64'sd0, 1'b1);

        // end positions, then switch to the unused code mid-sequence
        write_mode(MODE_LAST);
        queue_sample(64'sd0, 1'b0);
        queue_sample(MOST_NEG, 1'b0);
        queue_sample(64'sd0, 1'b0);
        queue_sample(-64'sd1, 1'b0);
        write_mode(MODE_UNUSED);
        queue_sample(64'sd5, 1'b0);
        queue_sample(64'sd0, 1'b1);
        write_mode(MODE_LAST);
        queue_sample(64'sd1, 1'b1);
        queue_sample(64'sh2, 1'b0);
        queue_sample(64'sd0, 1'b1);

        // random phases; some leave a sequence open across the mode change
        for (int unsigned phase = 0; phase < 12; phase++)
        begin
            if (phase < 4)
                m = mode_t'(phase);
            else
                m = ($urandom_range(0, 7) == 7) ? MODE_UNUSED : mode_t'($urandom_range(0, 2));
            write_mode(m);
            start = items_queued;
            while (items_queued - start < 110)
            begin
                if ($urandom_range(0, 6) == 0)
                    queue_sample(($urandom_range(0, 1) == 0) ? 64'sd0 : random_set_value(),
                                 $urandom_range(0, 19) == 0);
                else
                    queue_sequence(1'b0);
            end
            if ($urandom_range(0, 2) == 0)
                queue_sequence(1'b1);
        end
        queue_sample(64'sd0, 1'b1);

        // last part, no idling: back-to-back requests in each active mode
        settle();
        idling_on = 1'b0;
        for (int unsigned phase = 0; phase < 3; phase++)
        begin
            write_mode(mode_t'(phase));
            for (int unsigned i = 0; i < 2; i++)
                queue_sequence(1'b0);
        end

        settle();
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
